// File: design/crf_pkg.sv
// ============================================================================
// crf_pkg: capture record framer shared types and constants
// Beat layouts, job layout for the front/back queue, and framing constants.
// ============================================================================
`default_nettype none

package crf_pkg;

    localparam int DESC_RING_BYTES = 4096;
    localparam int BUF_RING_BYTES  = 65536;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_DESCRIPTOR = 1'b0;
    localparam logic CMD_PAYLOAD    = 1'b1;

    localparam logic JOB_HEADER  = 1'b0;
    localparam logic JOB_PAYLOAD = 1'b1;

    localparam logic [15:0] EMPTY_MARK     = 16'hffff;
    localparam logic [31:0] BLOCK_TYPE_EPB = 32'd6;
    localparam logic [16:0] BLOCK_OVERHEAD = 17'd32;
    localparam logic [12:0] DESC_STEP      = 13'd64;
    localparam logic [29:0] NS_PER_SECOND  = 30'd1000000000;

    localparam int PORT_BIT_IF0 = 9;
    localparam int PORT_BIT_IF1 = 11;
    localparam int PORT_BIT_IF2 = 13;
    localparam int PORT_BIT_IF3 = 15;

    localparam logic [2:0] IFACE_0    = 3'd0;
    localparam logic [2:0] IFACE_1    = 3'd1;
    localparam logic [2:0] IFACE_2    = 3'd2;
    localparam logic [2:0] IFACE_3    = 3'd3;
    localparam logic [2:0] IFACE_NONE = 3'd4;

    typedef struct packed {
        logic        command;
        logic [63:0] descriptor_word;
        logic [63:0] capture_time;
        logic [31:0] payload_word;
    } crf_item_t;

    typedef struct packed {
        logic [31:0] record_word;
        logic        record_end;
        logic [11:0] descriptor_ring_head;
        logic [15:0] buffer_ring_head;
    } crf_result_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] data;
        logic        last;
        logic [16:0] total_len;
        logic [2:0]  iface;
        logic [63:0] capture_time;
        logic [11:0] desc_head;
        logic [15:0] buf_head;
    } crf_job_t;

endpackage

`default_nettype wire

// File: design/crf_front.sv
// ============================================================================
// crf_front: item classifier
// Classifies descriptor and payload beats, keeps record state and ring heads,
// and writes one job per productive beat into the queue.
// ============================================================================
`default_nettype none

module crf_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire crf_pkg::crf_item_t item,
    output logic                   full,
    input  wire logic              q_full,
    output logic                   q_push,
    output crf_pkg::crf_job_t      q_job
);
    import crf_pkg::*;

    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [16:0] total_len_reg, total_len_next;
    logic [11:0] desc_head_reg, desc_head_next;
    logic [15:0] buf_head_reg, buf_head_next;

    logic        accept;
    logic        is_empty;
    logic [15:0] len;
    logic [15:0] ports;
    logic [16:0] round4;
    logic [16:0] round64;
    logic [12:0] desc_sum;
    logic [17:0] buf_sum;
    logic [2:0]  iface;
    logic [31:0] mask;
    logic        last_word;

    assign full   = q_full;
    assign accept = push && !q_full;

    assign len      = item.descriptor_word[15:0];
    assign ports    = item.descriptor_word[31:16];
    assign is_empty = item.descriptor_word[63:48] == EMPTY_MARK;
    assign round4   = (17'(len) + 17'd3) & ~17'd3;
    assign round64  = (17'(len) + 17'd63) & ~17'd63;
    assign desc_sum = 13'(desc_head_reg) + DESC_STEP;
    assign buf_sum  = 18'(buf_head_reg) + 18'(round64);

    always_comb
    begin
        if (ports[PORT_BIT_IF0])
            iface = IFACE_0;
        else if (ports[PORT_BIT_IF1])
            iface = IFACE_1;
        else if (ports[PORT_BIT_IF2])
            iface = IFACE_2;
        else if (ports[PORT_BIT_IF3])
            iface = IFACE_3;
        else
            iface = IFACE_NONE;
    end

    always_comb
    begin
        case (bytes_left_reg)
            16'd1:   mask = 32'h0000_00ff;
            16'd2:   mask = 32'h0000_ffff;
            16'd3:   mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase
    end

    assign last_word = bytes_left_reg <= 16'd4;

    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        total_len_next  = total_len_reg;
        desc_head_next  = desc_head_reg;
        buf_head_next   = buf_head_reg;
        q_push          = 1'b0;
        q_job           = '0;

        if (accept && item.command == CMD_DESCRIPTOR && !is_empty)
        begin
            bytes_left_next = len;
            total_len_next  = BLOCK_OVERHEAD + round4;
            if (32'(desc_sum) >= DESC_RING_BYTES)
                desc_head_next = 12'(32'(desc_sum) - DESC_RING_BYTES);
            else
                desc_head_next = desc_sum[11:0];
            if (32'(buf_sum) >= BUF_RING_BYTES)
                buf_head_next = 16'(32'(buf_sum) - BUF_RING_BYTES);
            else
                buf_head_next = buf_sum[15:0];
            q_push = 1'b1;
            q_job.kind         = JOB_HEADER;
            q_job.data         = 32'(len);
            q_job.last         = len == 16'd0;
            q_job.total_len    = total_len_next;
            q_job.iface        = iface;
            q_job.capture_time = item.capture_time;
            q_job.desc_head    = desc_head_next;
            q_job.buf_head     = buf_head_next;
        end
        else if (accept && item.command == CMD_PAYLOAD && bytes_left_reg != 16'd0)
        begin
            bytes_left_next = last_word ? 16'd0 : bytes_left_reg - 16'd4;
            q_push = 1'b1;
            q_job.kind         = JOB_PAYLOAD;
            q_job.data         = item.payload_word & mask;
            q_job.last         = last_word;
            q_job.total_len    = total_len_reg;
            q_job.iface        = IFACE_NONE;
            q_job.capture_time = item.capture_time;
            q_job.desc_head    = desc_head_reg;
            q_job.buf_head     = buf_head_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            total_len_reg  <= '0;
            desc_head_reg  <= '0;
            buf_head_reg   <= '0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
            total_len_reg  <= total_len_next;
            desc_head_reg  <= desc_head_next;
            buf_head_reg   <= buf_head_next;
        end
    end

endmodule

`default_nettype wire

// File: design/crf_queue.sv
// ============================================================================
// crf_queue: job queue
// Short register queue that decouples the classifier from the word emitter.
// ============================================================================
`default_nettype none

module crf_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire crf_pkg::crf_job_t wr_job,
    output logic                  q_full,
    input  wire logic             rd_en,
    output logic                  q_valid,
    output crf_pkg::crf_job_t     rd_job
);
    import crf_pkg::*;

    crf_job_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;

    assign q_full  = count_reg == QUEUE_CW'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign rd_job  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: design/crf_back.sv
// ============================================================================
// crf_back: record word emitter
// Expands each job into record words, converts the timestamp with one shared
// multiplier, and holds the outgoing beat in an output register.
// ============================================================================
`default_nettype none

module crf_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire crf_pkg::crf_job_t job,
    output logic                  q_pop,
    output logic                  empty,
    input  wire logic             pop,
    output crf_pkg::crf_result_t  result
);
    import crf_pkg::*;

    localparam logic [2:0] STEP_TYPE      = 3'd0;
    localparam logic [2:0] STEP_BLOCK_LEN = 3'd1;
    localparam logic [2:0] STEP_IFACE     = 3'd2;
    localparam logic [2:0] STEP_TS_HI     = 3'd3;
    localparam logic [2:0] STEP_TS_LO     = 3'd4;
    localparam logic [2:0] STEP_CAP_LEN   = 3'd5;
    localparam logic [2:0] STEP_PKT_LEN   = 3'd6;
    localparam logic [2:0] STEP_HDR_TRAIL = 3'd7;
    localparam logic [2:0] STEP_PAY_WORD  = 3'd0;
    localparam logic [2:0] STEP_PAY_TRAIL = 3'd1;

    logic [2:0]  step_reg, step_next;
    logic [61:0] sec_ns_reg;
    logic [29:0] frac_ns_reg;
    logic [63:0] ns_reg;
    crf_result_t out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic        advance;
    logic [31:0] mul_a;
    logic [61:0] mul_out;
    logic [2:0]  main_last;
    logic [2:0]  trail_step;
    logic        at_trail;
    logic        done;
    logic [31:0] word;

    assign advance = q_valid && (!out_valid_reg || pop);
    assign empty   = !out_valid_reg;
    assign result  = out_reg;

    assign mul_a   = (step_reg == STEP_TYPE) ? job.capture_time[63:32]
                                             : job.capture_time[31:0];
    assign mul_out = 62'(mul_a) * 62'(NS_PER_SECOND);

    assign main_last  = (job.kind == JOB_HEADER) ? STEP_PKT_LEN : STEP_PAY_WORD;
    assign trail_step = (job.kind == JOB_HEADER) ? STEP_HDR_TRAIL : STEP_PAY_TRAIL;
    assign at_trail   = step_reg == trail_step;
    assign done       = at_trail || (step_reg == main_last && !job.last);
    assign q_pop      = advance && done;

    always_comb
    begin
        if (at_trail)
            word = 32'(job.total_len);
        else if (job.kind == JOB_PAYLOAD)
            word = job.data;
        else
        begin
            case (step_reg)
                STEP_TYPE:      word = BLOCK_TYPE_EPB;
                STEP_BLOCK_LEN: word = 32'(job.total_len);
                STEP_IFACE:     word = 32'(job.iface);
                STEP_TS_HI:     word = ns_reg[63:32];
                STEP_TS_LO:     word = ns_reg[31:0];
                default:        word = job.data;
            endcase
        end
    end

    always_comb
    begin
        step_next      = step_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        if (advance)
        begin
            step_next = done ? STEP_TYPE : step_reg + 3'd1;
            out_next.record_word          = word;
            out_next.record_end           = at_trail;
            out_next.descriptor_ring_head = job.desc_head;
            out_next.buffer_ring_head     = job.buf_head;
            out_valid_next                = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (advance && job.kind == JOB_HEADER)
        begin
            if (step_reg == STEP_TYPE)
                sec_ns_reg <= mul_out;
            if (step_reg == STEP_BLOCK_LEN)
                frac_ns_reg <= mul_out[61:32];
            if (step_reg == STEP_IFACE)
                ns_reg <= 64'(sec_ns_reg) + 64'(frac_ns_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_TYPE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_step_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != STEP_TYPE) |-> q_valid)
        else $error("record step advanced without a job at the queue head");

    a_payload_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && job.kind == JOB_PAYLOAD) |-> (step_reg <= STEP_PAY_TRAIL))
        else $error("payload job step out of range");

    a_beat_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_reg)))
        else $error("waiting result beat lost or changed");

endmodule

`default_nettype wire

// File: design/capture_record_framer_top.sv
// ============================================================================
// capture_record_framer_top: capture record framer
// Builds enhanced packet block words from receive descriptors and payload.
//
//   channel | direction | handshake       | beat
//   --------+-----------+-----------------+--------------------------------
//   item    | in        | push / full     | command, descriptor, time, data
//   result  | out       | pop / empty     | word, end flag, ring heads
//
// One input beat is taken per cycle while the job queue has room.
// Result beats leave at one per cycle while pop is held; a descriptor yields 7 or 8 beats,
// a payload beat 1 or 2, so the word emitter sets the sustained rate.
// A result passes through a job queue entry and then the output register.
// Reset clears record state, ring heads, the queue and the output beat.
// A stalled output holds its beat; input keeps flowing until the queue fills.
// ============================================================================
`default_nettype none

module capture_record_framer_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire crf_pkg::crf_item_t  item,
    output logic                    full,
    output logic                    empty,
    input  wire logic               pop,
    output crf_pkg::crf_result_t    result
);
    import crf_pkg::*;

    logic     q_full;
    logic     q_push;
    crf_job_t q_wr_job;
    logic     q_valid;
    logic     q_pop;
    crf_job_t q_rd_job;

    crf_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (q_wr_job)
    );

    crf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_job  (q_wr_job),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_valid (q_valid),
        .rd_job  (q_rd_job)
    );

    crf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .job     (q_rd_job),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

// File: verif/tb_capture_record_framer_top.sv
// ============================================================================
// tb_capture_record_framer_top: capture record framer testbench
// Pushes descriptor and payload beats through the push/full side. A local
// mirror of the record state predicts every enhanced packet block word and
// the ring heads it carries. The pop/empty side is checked in order while
// both sides idle and stall at random, with a quiet stretch at the end.
// ============================================================================
`default_nettype none

module tb_capture_record_framer_top;

    import crf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    crf_item_t   item = '0;
    logic        full;
    logic        empty;
    logic        pop = 1'b0;
    crf_result_t result;

    capture_record_framer_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .full  (full),
        .empty (empty),
        .pop   (pop),
        .result(result)
    );

    logic [15:0] bytes_due = '0;
    logic [31:0] total_len = '0;
    logic [11:0] desc_head = '0;
    logic [15:0] buf_head  = '0;

    crf_result_t record_words[$];
    int          mismatches   = 0;
    int          cycles       = 0;
    int          framed_beats = 0;
    int          gap_odds     = 0;
    int          stall_odds   = 0;
    int          stall_left   = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL capture_record_framer_top");
            $finish;
        end
    end

    function automatic void queue_word(logic [31:0] word, logic last);
        crf_result_t r;
        r.record_word          = word;
        r.record_end           = last;
        r.descriptor_ring_head = desc_head;
        r.buffer_ring_head     = buf_head;
        record_words.push_back(r);
    endfunction

    task automatic frame_item(input crf_item_t it, output bit framed);
        logic [15:0] len;
        logic [15:0] ports;
        logic [16:0] round4;
        logic [16:0] round64;
        logic [63:0] ns;
        logic [2:0]  iface;
        logic [15:0] take;
        logic [31:0] mask;
        framed = 1'b0;
        if (it.command == CMD_DESCRIPTOR)
        begin
            if (it.descriptor_word[63:48] != EMPTY_MARK)
            begin
                framed  = 1'b1;
                len     = it.descriptor_word[15:0];
                ports   = it.descriptor_word[31:16];
                round4  = (17'(len) + 17'd3) & ~17'd3;
                round64 = (17'(len) + 17'd63) & ~17'd63;
                ns = 64'(it.capture_time[63:32]) * 64'(NS_PER_SECOND)
                   + ((64'(it.capture_time[31:0]) * 64'(NS_PER_SECOND)) >> 32);
                if (ports[PORT_BIT_IF0])
                    iface = IFACE_0;
                else if (ports[PORT_BIT_IF1])
                    iface = IFACE_1;
                else if (ports[PORT_BIT_IF2])
                    iface = IFACE_2;
                else if (ports[PORT_BIT_IF3])
                    iface = IFACE_3;
                else
                    iface = IFACE_NONE;
                total_len = 32'(BLOCK_OVERHEAD) + 32'(round4);
                bytes_due = len;
                desc_head = 12'((int'(desc_head) + int'(DESC_STEP)) % DESC_RING_BYTES);
                buf_head  = 16'((int'(buf_head) + int'(round64)) % BUF_RING_BYTES);
                queue_word(BLOCK_TYPE_EPB, 1'b0);
                queue_word(total_len, 1'b0);
                queue_word(32'(iface), 1'b0);
                queue_word(ns[63:32], 1'b0);
                queue_word(ns[31:0], 1'b0);
                queue_word(32'(len), 1'b0);
                queue_word(32'(len), 1'b0);
                if (len == 16'd0)
                    queue_word(total_len, 1'b1);
            end
        end
        else if (bytes_due != 16'd0)
        begin
            framed    = 1'b1;
            take      = (bytes_due < 16'd4) ? bytes_due : 16'd4;
            mask      = (take == 16'd4) ? 32'hffff_ffff : ((32'd1 << (8 * take)) - 32'd1);
            bytes_due = bytes_due - take;
            queue_word(it.payload_word & mask, 1'b0);
            if (bytes_due == 16'd0)
                queue_word(total_len, 1'b1);
        end
    endtask

    function automatic crf_item_t desc_beat(logic [15:0] len, logic [15:0] ports,
                                            logic [63:0] stamp);
        crf_item_t it;
        it.command         = CMD_DESCRIPTOR;
        it.descriptor_word = {16'($urandom), 16'($urandom), ports, len};
        if (it.descriptor_word[63:48] == EMPTY_MARK)
            it.descriptor_word[48] = 1'b0;
        it.capture_time    = stamp;
        it.payload_word    = $urandom;
        return it;
    endfunction

    function automatic crf_item_t empty_beat();
        crf_item_t it;
        it.command         = CMD_DESCRIPTOR;
        it.descriptor_word = {EMPTY_MARK, 16'($urandom), $urandom};
        it.capture_time    = {$urandom, $urandom};
        it.payload_word    = $urandom;
        return it;
    endfunction

    function automatic crf_item_t data_beat(logic [31:0] word);
        crf_item_t it;
        it.command         = CMD_PAYLOAD;
        it.descriptor_word = {$urandom, $urandom};
        it.capture_time    = {$urandom, $urandom};
        it.payload_word    = word;
        return it;
    endfunction

    task automatic send_beat(input crf_item_t it);
        bit framed;
        if (gap_odds > 0 && $urandom_range(0, 99) < gap_odds)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
        frame_item(it, framed);
        if (framed)
            framed_beats++;
    endtask

    task automatic send_record(input logic [15:0] len, input logic [15:0] ports,
                               input logic [63:0] stamp, input int words);
        send_beat(desc_beat(len, ports, stamp));
        repeat (words) send_beat(data_beat($urandom));
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge clk); while (record_words.size() != 0);
    endtask

    task automatic test_header_extremes();
        send_record(16'd0, 16'h0000, 64'd0, 0);
        send_record(16'd0, 16'h0200, 64'hffff_ffff_ffff_ffff, 0);
        send_record(16'd0, 16'h0800, 64'hffff_ffff_0000_0000, 0);
        send_record(16'd0, 16'h2000, 64'h0000_0000_ffff_ffff, 0);
        send_record(16'd0, 16'h8000, 64'h0000_0001_8000_0000, 0);
        send_record(16'd0, 16'hffff, {$urandom, $urandom}, 0);
        send_record(16'd0, 16'hd5ff, {$urandom, $urandom}, 0);
        send_beat(empty_beat());
        send_beat(data_beat(32'hffff_ffff));
        send_record(16'd1, 16'h0000, {$urandom, $urandom}, 1);
        send_record(16'd2, 16'h0a00, {$urandom, $urandom}, 1);
        send_record(16'd3, 16'h2800, {$urandom, $urandom}, 1);
        send_beat(desc_beat(16'd5, 16'h8000, {$urandom, $urandom}));
        send_beat(data_beat(32'hffff_ffff));
        send_beat(data_beat(32'hffff_ffff));
        // abandon a maximum-length record with a fresh descriptor
        send_record(16'hffff, 16'hffff, 64'hffff_ffff_ffff_ffff, 1);
        send_record(16'd4, 16'h0000, {$urandom, $urandom}, 1);
        send_beat(data_beat(32'h0000_0000));
    endtask

    task automatic test_random_records(input int target);
        int          pick;
        int          words;
        logic [15:0] len;
        logic [15:0] ports;
        target = framed_beats + target;
        while (framed_beats < target)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : 30;
                stall_odds = ($urandom_range(0, 2) == 0) ? 0 : 30;
            end
            pick  = $urandom_range(0, 99);
            ports = 16'($urandom);
            if ($urandom_range(0, 3) == 0)
                ports = ports & 16'h55ff;
            if (pick < 8)
                send_beat(empty_beat());
            else if (pick < 16)
                send_beat(data_beat($urandom));
            else if (pick < 24)
            begin
                len = 16'($urandom);
                send_record(len, ports, {$urandom, $urandom}, $urandom_range(0, 3));
            end
            else
            begin
                len   = (pick < 90) ? 16'($urandom_range(0, 40)) : 16'($urandom_range(41, 300));
                words = (int'(len) + 3) / 4;
                if ($urandom_range(0, 9) == 0 && words > 0)
                    words = $urandom_range(0, words - 1);
                send_record(len, ports, {$urandom, $urandom}, words);
            end
        end
    endtask

    task automatic test_drained_restart();
        wait_drained();
        send_record(16'd7, 16'h0800, {$urandom, $urandom}, 2);
    endtask

    task automatic test_steady_tail();
        logic [15:0] len;
        gap_odds   = 0;
        stall_odds = 0;
        repeat (20)
        begin
            len = 16'($urandom_range(0, 16));
            send_record(len, 16'($urandom), {$urandom, $urandom}, (int'(len) + 3) / 4);
        end
    endtask

    always @(posedge clk)
    begin
        crf_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (record_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: word %h end %b desc %h buf %h",
                             result.record_word, result.record_end,
                             result.descriptor_ring_head, result.buffer_ring_head);
            end
            else
            begin
                want = record_words.pop_front();
                if (result.record_word !== want.record_word
                    || result.record_end !== want.record_end
                    || result.descriptor_ring_head !== want.descriptor_ring_head
                    || result.buffer_ring_head !== want.buffer_ring_head)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp word %h end %b desc %h buf %h, got %h %b %h %h",
                                 want.record_word, want.record_end,
                                 want.descriptor_ring_head, want.buffer_ring_head,
                                 result.record_word, result.record_end,
                                 result.descriptor_ring_head, result.buffer_ring_head);
                end
            end
        end
        if (!rst_n)
            pop <= 1'b0;
        else if (stall_left > 0)
        begin
            pop <= 1'b0;
            stall_left--;
        end
        else if (stall_odds > 0 && $urandom_range(0, 99) < stall_odds)
        begin
            pop <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end
        else
            pop <= 1'b1;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        gap_odds   = 25;
        stall_odds = 25;
        test_header_extremes();
        test_random_records(100);
        test_drained_restart();
        test_random_records(100);
        test_steady_tail();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS capture_record_framer_top");
        else
            $display("FAIL capture_record_framer_top");
        $finish;
    end

endmodule

`default_nettype wire
